### hdl/atatf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atatf_pkg
// Types, constants and register-file helpers for the ATA task-file stub.
// ----------------------------------------------------------------------------
package atatf_pkg;

	localparam int NUM_CH_DEF = 2;
	localparam int MAX_DEC_CH = 2;
	localparam int LANES      = 4;

	// request codes
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_DMA   = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_PRI_CMD = 2'd0;
	localparam logic [1:0] CFG_PRI_CTL = 2'd1;
	localparam logic [1:0] CFG_SEC_CMD = 2'd2;
	localparam logic [1:0] CFG_SEC_CTL = 2'd3;

	localparam logic [15:0] PRI_CMD_RST = 16'h01F0;
	localparam logic [15:0] PRI_CTL_RST = 16'h03F6;
	localparam logic [15:0] SEC_CMD_RST = 16'h0170;
	localparam logic [15:0] SEC_CTL_RST = 16'h0376;

	// task-file offsets
	localparam logic [2:0] OFF_DATA   = 3'd0;
	localparam logic [2:0] OFF_ERR    = 3'd1;
	localparam logic [2:0] OFF_COUNT  = 3'd2;
	localparam logic [2:0] OFF_SECTOR = 3'd3;
	localparam logic [2:0] OFF_CYL_LO = 3'd4;
	localparam logic [2:0] OFF_CYL_HI = 3'd5;
	localparam logic [2:0] OFF_DEVHD  = 3'd6;
	localparam logic [2:0] OFF_STATUS = 3'd7;

	localparam logic [7:0] CMD_SET_FEATURES = 8'hEF;
	localparam logic [7:0] ERR_OK           = 8'h01;
	localparam logic [7:0] ERR_ABORT        = 8'h04;
	localparam logic [7:0] STAT_READY       = 8'h50;
	localparam logic [7:0] STAT_ERROR       = 8'h51;
	localparam logic [7:0] DEVHD_RST        = 8'hA0;
	localparam logic [7:0] UNMAPPED_BYTE    = 8'hFF;
	localparam int         CTL_NIEN_BIT     = 1;
	localparam int         CTL_SRST_BIT     = 2;
	localparam int         DEVHD_DEV_BIT    = 4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] port_address;
		logic [31:0] write_data;
		logic [2:0]  access_len;
		logic [1:0]  dma_channel;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_primary;
		logic        irq_secondary;
	} rsp_t;

	typedef struct packed {
		logic [7:0] err;
		logic [7:0] count;
		logic [7:0] sector;
		logic [7:0] cyl_lo;
		logic [7:0] cyl_hi;
		logic [7:0] dev_head;
		logic [7:0] stat;
		logic [7:0] ctl;
		logic [7:0] feat;
		logic       dev_select;
		logic       irq;
	} chan_t;

	localparam chan_t CHAN_RST = '{
		err: ERR_OK, count: 8'h01, sector: 8'h01, cyl_lo: 8'h00, cyl_hi: 8'h00,
		dev_head: DEVHD_RST, stat: STAT_READY, ctl: 8'h00, feat: 8'h00,
		dev_select: 1'b0, irq: 1'b0
	};

	function automatic chan_t chan_raise(input chan_t s);
		chan_t r;
		r = s;
		if (!s.ctl[CTL_NIEN_BIT])
			r.irq = 1'b1;
		return r;
	endfunction

	function automatic logic [7:0] lane_read(input chan_t s, input logic [2:0] off);
		logic [7:0] b;
		unique case (off)
			OFF_DATA:   b = 8'h00;
			OFF_ERR:    b = s.err;
			OFF_COUNT:  b = s.count;
			OFF_SECTOR: b = s.sector;
			OFF_CYL_LO: b = s.cyl_lo;
			OFF_CYL_HI: b = s.cyl_hi;
			OFF_DEVHD:  b = s.dev_head;
			OFF_STATUS: b = s.stat;
			default:    b = UNMAPPED_BYTE;
		endcase
		return b;
	endfunction

	function automatic chan_t lane_write(input chan_t s, input logic [2:0] off,
			input logic alt, input logic [7:0] v);
		chan_t r;
		r = s;
		if (alt) begin
			r.ctl = v;
			if (v[CTL_SRST_BIT])
				r = CHAN_RST;
		end else begin
			unique case (off)
				OFF_DATA:   r = s;
				OFF_ERR:    r.feat = v;
				OFF_COUNT:  r.count = v;
				OFF_SECTOR: r.sector = v;
				OFF_CYL_LO: r.cyl_lo = v;
				OFF_CYL_HI: r.cyl_hi = v;
				OFF_DEVHD: begin
					r.dev_head   = v;
					r.dev_select = v[DEVHD_DEV_BIT];
				end
				OFF_STATUS: begin
					if (v == CMD_SET_FEATURES) begin
						r.err  = ERR_OK;
						r.stat = STAT_READY;
					end else begin
						r.err  = ERR_ABORT;
						r.stat = STAT_ERROR;
					end
					r = chan_raise(r);
				end
				default: r = s;
			endcase
		end
		return r;
	endfunction

endpackage

### hdl/ata_task_file_stub_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_task_file_stub_controller
// Two-channel ATA task-file register stub with byte-lane decode.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid / in_stall / in_data: an I/O read or write of
//   one to four consecutive byte ports, or a DMA completion event. A transfer
//   happens when valid is high and stall is low. Each request gives exactly
//   one response on out_valid / out_stall / out_data with the read bytes and
//   both interrupt line levels after the request. A request passes the input
//   register, then the result register. Throughput is one request per cycle
//   unless the receiver stalls; the four byte lanes are decoded side by side
//   and applied lowest port first in one pass. When the receiver stalls, the
//   result register holds and in_stall rises once the input register is also
//   full; no request is lost. Base ports are written through cfg_we /
//   cfg_index / cfg_data; the user must write them only while idle, as the
//   block does not enforce it. Reset restores the default base ports and the
//   power-on task file of every channel, with interrupt lines low.
// ----------------------------------------------------------------------------
module ata_task_file_stub_controller #(
	parameter int NUM_CHANNELS = atatf_pkg::NUM_CH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  atatf_pkg::req_t   in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output atatf_pkg::rsp_t   out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import atatf_pkg::*;

	localparam int ACT_CH = (NUM_CHANNELS < MAX_DEC_CH) ? NUM_CHANNELS : MAX_DEC_CH;

	logic [15:0] cmd_base_q [MAX_DEC_CH];
	logic [15:0] ctl_port_q [MAX_DEC_CH];
	chan_t       chan_q [ACT_CH];
	chan_t       chan_nxt [ACT_CH];

	logic        valid_s1;
	req_t        req_s1;
	logic        out_valid_q;
	rsp_t        out_data_q;
	logic        advance;
	rsp_t        rsp;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_base_q[0] <= PRI_CMD_RST;
			ctl_port_q[0] <= PRI_CTL_RST;
			cmd_base_q[1] <= SEC_CMD_RST;
			ctl_port_q[1] <= SEC_CTL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRI_CMD: cmd_base_q[0] <= cfg_data;
				CFG_PRI_CTL: ctl_port_q[0] <= cfg_data;
				CFG_SEC_CMD: cmd_base_q[1] <= cfg_data;
				CFG_SEC_CTL: ctl_port_q[1] <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			req_s1 <= in_data;
	end

	// lane decode and task-file update, lowest port first
	always_comb begin
		logic [16:0]       lane_port;
		logic [16:0]       base17;
		logic [16:0]       diff;
		logic [ACT_CH-1:0] sel;
		logic [2:0]        off;
		logic              alt;
		logic              hit;
		logic [7:0]        rbyte;
		logic [1:0]        irq_vec;

		for (int c = 0; c < ACT_CH; c++)
			chan_nxt[c] = chan_q[c];
		rsp = '0;

		for (int i = 0; i < LANES; i++) begin
			lane_port = {1'b0, req_s1.port_address} + 17'(i);
			sel = '0;
			off = OFF_DATA;
			alt = 1'b0;
			hit = 1'b0;
			rbyte = UNMAPPED_BYTE;
			for (int c = 0; c < ACT_CH; c++) begin
				base17 = {1'b0, cmd_base_q[c]};
				diff   = lane_port - base17;
				if (!hit) begin
					if (lane_port >= base17 && lane_port <= base17 + 17'd7) begin
						hit    = 1'b1;
						sel[c] = 1'b1;
						off    = diff[2:0];
						alt    = 1'b0;
					end else if (lane_port == {1'b0, ctl_port_q[c]}) begin
						hit    = 1'b1;
						sel[c] = 1'b1;
						off    = OFF_STATUS;
						alt    = 1'b1;
					end
				end
			end

			if (req_s1.access_len > 3'(i)) begin
				unique case (req_s1.req_type)
					REQ_READ: begin
						for (int c = 0; c < ACT_CH; c++) begin
							if (sel[c]) begin
								// register values are untouched by reads; a status read clears the channel's irq
								rbyte = lane_read(chan_q[c], off);
								if (off == OFF_STATUS && !alt)
									chan_nxt[c].irq = 1'b0;
							end
						end
						rsp.read_data[8*i +: 8] = rbyte;
					end
					REQ_WRITE: begin
						for (int c = 0; c < ACT_CH; c++)
							if (sel[c])
								chan_nxt[c] = lane_write(chan_nxt[c], off, alt,
									req_s1.write_data[8*i +: 8]);
					end
					default: ;
				endcase
			end
		end

		if (req_s1.req_type == REQ_DMA) begin
			for (int c = 0; c < ACT_CH; c++)
				if (req_s1.dma_channel == 2'(c))
					chan_nxt[c] = chan_raise(chan_nxt[c]);
		end

		irq_vec = '0;
		for (int c = 0; c < ACT_CH; c++)
			irq_vec[c] = chan_nxt[c].irq;
		rsp.irq_primary   = irq_vec[0];
		rsp.irq_secondary = irq_vec[1];
	end

	// commit state and result together as the request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < ACT_CH; c++)
				chan_q[c] <= CHAN_RST;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				for (int c = 0; c < ACT_CH; c++)
					chan_q[c] <= chan_nxt[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			out_data_q <= rsp;
	end

endmodule
